// ===== hw/rtl/sbb_pkg.sv =====
// Shared types, constants and width helpers for the sliding box blur row block.
// No dependencies; the divider cell, window, top level and testbench import it.
package sbb_pkg;

   localparam int CHAN_W       = 8;
   localparam int NUM_CHAN     = 3;
   localparam int PIXEL_W      = CHAN_W * NUM_CHAN;
   localparam int STORE_DEPTH  = 64;
   localparam int STORE_AW     = $clog2(STORE_DEPTH);

   localparam int CFG_WIDTH_W  = 10;
   localparam int CFG_COUNT_W  = 10;
   localparam int CFG_RADIUS_W = 5;
   localparam int CSR_DATA_W   = 10;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [CFG_WIDTH_W-1:0]  RESET_ROW_WIDTH   = 10'd128;
   localparam logic [CFG_COUNT_W-1:0]  RESET_ROW_COUNT   = 10'd64;
   localparam logic [CFG_RADIUS_W-1:0] RESET_BLUR_RADIUS = 5'd2;

   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 512;
   localparam int DEF_MAX_RADIUS = 28;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_WIDTH   = 2'd0,
      CSR_ROW_COUNT   = 2'd1,
      CSR_BLUR_RADIUS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic run_last;
      logic frame_end;
      logic row_end;
   } flags_type;

   typedef struct packed {
      logic flushing;
   } status_type;

   // Width of a window sum: up to 2*R+1 pixels of full scale.
   function automatic int sum_width(input int max_radius);
      return $clog2((2 * max_radius + 1) * 255 + 1);
   endfunction

   // Width of a window pixel count, 1 .. 2*R+1.
   function automatic int count_width(input int max_radius);
      return $clog2(2 * max_radius + 2);
   endfunction

endpackage

// ===== hw/rtl/sbb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// A read at the address being written returns the new data. No dependencies.
module sbb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sbb_div_cell.sv =====
// One cell of the divider chain: settles quotient bit BIT of all three channels.
// Depends on sbb_pkg; instantiated in a row by the top level.
module sbb_div_cell
   import sbb_pkg::*;
#(
   parameter int SW  = 14,
   parameter int NW  = 6,
   parameter int BIT = 7
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [NUM_CHAN-1:0][SW-1:0]         in_rem,
   input  logic [NUM_CHAN-1:0][CHAN_W-1:0]     in_quo,
   input  logic [NW-1:0]                       in_count,
   input  flags_type                           in_flags,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [NUM_CHAN-1:0][SW-1:0]         out_rem,
   output logic [NUM_CHAN-1:0][CHAN_W-1:0]     out_quo,
   output logic [NW-1:0]                       out_count,
   output flags_type                           out_flags
);

   localparam int TW = (SW > NW + BIT) ? SW : NW + BIT;

   logic                            valid_ff, valid_in;
   logic [NUM_CHAN-1:0][SW-1:0]     rem_ff, rem_in;
   logic [NUM_CHAN-1:0][CHAN_W-1:0] quo_ff, quo_in;
   logic [NW-1:0]                   count_ff;
   flags_type                       flags_ff;
   logic                            load;
   logic [TW-1:0]                   divisor;
   logic [TW-1:0]                   rem_ext;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      divisor = TW'(in_count) << BIT;
      rem_in  = in_rem;
      quo_in  = in_quo;
      rem_ext = '0;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         rem_ext = TW'(in_rem[ch]);
         if (rem_ext >= divisor) begin
            rem_in[ch]      = SW'(rem_ext - divisor);
            quo_in[ch][BIT] = 1'b1;
         end
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         rem_ff   <= rem_in;
         quo_ff   <= quo_in;
         count_ff <= in_count;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_count = count_ff;
   assign out_flags = flags_ff;

endmodule

// ===== hw/rtl/sbb_window.sv =====
// Window sequencer: configuration registers, pixel store, running sums and the
// emit register that feeds the divider chain. Depends on sbb_pkg and sbb_ram.
module sbb_window
   import sbb_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = DEF_MAX_RADIUS,
   parameter int SW         = sum_width(DEF_MAX_RADIUS),
   parameter int NW         = count_width(DEF_MAX_RADIUS)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [CSR_INDEX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]           csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [PIXEL_W-1:0]              req_tdata,
   output logic                            emit_valid,
   input  logic                            emit_ready,
   output logic [NUM_CHAN-1:0][SW-1:0]     emit_sum,
   output logic [NW-1:0]                   emit_count,
   output flags_type                       emit_flags,
   output status_type                      status
);

   localparam int CLW = $clog2(MAX_WIDTH);
   localparam int XW  = $clog2(MAX_WIDTH + 64);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int RIW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   typedef enum logic {ST_RUN, ST_FLUSH} state_type;

   state_type                   state_ff, state_in;
   logic [CFG_WIDTH_W-1:0]      width_ff, width_in;
   logic [CFG_COUNT_W-1:0]      height_ff, height_in;
   logic [CFG_RADIUS_W-1:0]     radius_ff, radius_in;
   logic [CLW-1:0]              in_col_ff, in_col_in;
   logic [CLW-1:0]              out_col_ff, out_col_in;
   logic [RIW-1:0]              row_ff, row_in;
   logic [NUM_CHAN-1:0][SW-1:0] sum_ff, sum_in;
   logic                        emit_valid_ff, emit_valid_in;
   logic [NUM_CHAN-1:0][SW-1:0] emit_sum_ff, emit_sum_in;
   logic [NW-1:0]               emit_count_ff, emit_count_in;
   flags_type                   emit_flags_ff, emit_flags_in;

   logic [XW-1:0]                   w_eff, x_w, c_w, r_w, lo, hi;
   logic [HW-1:0]                   h_eff;
   logic [CFG_RADIUS_W-1:0]         r_eff;
   logic [NUM_CHAN-1:0][CHAN_W-1:0] pix, old_pix, rd_pix;
   logic [NUM_CHAN-1:0][SW-1:0]     sum_tmp, sum_sub;
   logic [NW-1:0]                   count;
   flags_type                       flags;
   logic                            free, accept, last_in, window_full, row_done;
   logic                            row_last, emit_go, csr_hit;
   logic [STORE_AW-1:0]             rd_addr;
   logic [PIXEL_W-1:0]              rd_data;

   // Effective configuration, out-of-range values folded into range.
   always_comb begin
      if (width_ff == '0) begin
         w_eff = XW'(1);
      end else if (width_ff > MAX_WIDTH) begin
         w_eff = XW'(MAX_WIDTH);
      end else begin
         w_eff = XW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HW'(1);
      end else if (height_ff > MAX_HEIGHT) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(height_ff);
      end
      if (radius_ff > MAX_RADIUS) begin
         r_eff = CFG_RADIUS_W'(MAX_RADIUS);
      end else begin
         r_eff = radius_ff;
      end
   end

   assign pix        = req_tdata;
   assign rd_pix     = rd_data;
   assign free       = !emit_valid_ff || emit_ready;
   assign req_tready = (state_ff == ST_RUN) && free;
   assign accept     = req_tvalid && req_tready;

   assign x_w = XW'(out_col_ff);
   assign c_w = XW'(in_col_ff);
   assign r_w = XW'(r_eff);

   assign last_in     = (c_w + XW'(1)) >= w_eff;
   assign window_full = (x_w + r_w) <= c_w;
   assign row_done    = (x_w + XW'(1)) >= w_eff;
   assign row_last    = (HW'(row_ff) + HW'(1)) >= h_eff;
   assign lo          = (x_w > r_w) ? x_w - r_w : '0;
   assign hi          = ((x_w + r_w) < w_eff) ? x_w + r_w : w_eff - XW'(1);
   assign count       = NW'(hi - lo + XW'(1));

   assign emit_go = (accept && (last_in || window_full)) ||
                    ((state_ff == ST_FLUSH) && free);

   // With no radius the leaving pixel is the one arriving in this beat.
   assign old_pix = (r_eff == '0) ? pix : rd_pix;

   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         sum_tmp[ch] = accept ? sum_ff[ch] + SW'(pix[ch]) : sum_ff[ch];
         sum_sub[ch] = (x_w >= r_w) ? sum_tmp[ch] - SW'(old_pix[ch]) : sum_tmp[ch];
      end
      flags.row_end   = row_done;
      flags.frame_end = row_done && row_last;
      flags.run_last  = row_done || ((state_ff == ST_RUN) && !last_in);
   end

   assign csr_hit = csr_write && ((csr_index == CSR_ROW_WIDTH) ||
                                  (csr_index == CSR_ROW_COUNT) ||
                                  (csr_index == CSR_BLUR_RADIUS));

   always_comb begin
      state_in      = state_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      radius_in     = radius_ff;
      in_col_in     = in_col_ff;
      out_col_in    = out_col_ff;
      row_in        = row_ff;
      sum_in        = sum_ff;
      emit_valid_in = emit_valid_ff && !emit_ready;
      emit_sum_in   = emit_sum_ff;
      emit_count_in = emit_count_ff;
      emit_flags_in = emit_flags_ff;

      if (accept) begin
         in_col_in = last_in ? '0 : CLW'(c_w + XW'(1));
         sum_in    = sum_tmp;
         if (last_in && !row_done) begin
            state_in = ST_FLUSH;
         end
      end

      if (emit_go) begin
         emit_valid_in = 1'b1;
         emit_sum_in   = sum_tmp;
         emit_count_in = count;
         emit_flags_in = flags;
         if (row_done) begin
            out_col_in = '0;
            sum_in     = '0;
            row_in     = row_last ? '0 : RIW'(HW'(row_ff) + HW'(1));
            state_in   = ST_RUN;
         end else begin
            out_col_in = CLW'(x_w + XW'(1));
            sum_in     = sum_sub;
         end
      end

      // Any register write restarts the frame.
      if (csr_hit) begin
         case (csr_index)
            CSR_ROW_WIDTH:   width_in  = csr_wdata[CFG_WIDTH_W-1:0];
            CSR_ROW_COUNT:   height_in = csr_wdata[CFG_COUNT_W-1:0];
            CSR_BLUR_RADIUS: radius_in = csr_wdata[CFG_RADIUS_W-1:0];
            default:         width_in  = width_ff;
         endcase
         in_col_in  = '0;
         out_col_in = '0;
         row_in     = '0;
         sum_in     = '0;
         state_in   = ST_RUN;
      end
   end

   // The store is read every cycle at the column that leaves the next window,
   // so the data is ready when that output is emitted.
   assign rd_addr = STORE_AW'(out_col_in) - STORE_AW'(r_eff);

   sbb_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (STORE_AW'(in_col_ff)),
      .wr_data (req_tdata),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         width_ff      <= RESET_ROW_WIDTH;
         height_ff     <= RESET_ROW_COUNT;
         radius_ff     <= RESET_BLUR_RADIUS;
         in_col_ff     <= '0;
         out_col_ff    <= '0;
         row_ff        <= '0;
         sum_ff        <= '0;
         emit_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         radius_ff     <= radius_in;
         in_col_ff     <= in_col_in;
         out_col_ff    <= out_col_in;
         row_ff        <= row_in;
         sum_ff        <= sum_in;
         emit_valid_ff <= emit_valid_in;
      end
      emit_sum_ff   <= emit_sum_in;
      emit_count_ff <= emit_count_in;
      emit_flags_ff <= emit_flags_in;
   end

   assign emit_valid      = emit_valid_ff;
   assign emit_sum        = emit_sum_ff;
   assign emit_count      = emit_count_ff;
   assign emit_flags      = emit_flags_ff;
   assign status.flushing = (state_ff == ST_FLUSH);

endmodule

// ===== hw/rtl/sliding_box_blur_row.sv =====
// Horizontal box blur of an RGB pixel stream, one row at a time.
// Pixels enter on the req_ channel in row order, red in the low byte. Each
// output column is the per-channel floor average of the input columns within
// the blur radius, clipped at the row edges. Results leave on the rsp_
// channel with row_end and frame_end in tuser and tlast on the last result
// caused by an input beat.
// Inside a row one pixel is taken per cycle unless the divider chain stalls;
// output x is emitted with input x+radius. The last pixel of a row emits the
// first trailing output in its own cycle and the remaining radius outputs at
// one per cycle as the chain takes them, during which req_ is not ready. The
// window sequencer's running-sum update limits it to one output per cycle.
// Each result then passes the emit register and an eight-cell divider chain,
// one quotient bit per cell. A stalled receiver holds the last cell; beats
// still enter while earlier cells have room. Reset loads width 128, 64 rows
// and radius 2 and starts a frame; the pixel store needs no clearing pass.
// Register writes through the csr_ port restart the frame; the user is to
// make them only while the block is idle, as the block does not enforce it.
module sliding_box_blur_row
   import sbb_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PIXEL_W-1:0]     req_tdata,   // in_red, in_green, in_blue
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [PIXEL_W-1:0]     rsp_tdata,   // out_red, out_green, out_blue
   output logic [1:0]             rsp_tuser,   // row_end, frame_end
   output logic                   rsp_tlast
);

   localparam int SW     = sum_width(MAX_RADIUS);
   localparam int NW     = count_width(MAX_RADIUS);
   localparam int STAGES = CHAN_W;

   logic                            valid_st [0:STAGES];
   logic                            ready_st [0:STAGES];
   logic [NUM_CHAN-1:0][SW-1:0]     rem_st   [0:STAGES-1];
   logic [NUM_CHAN-1:0][CHAN_W-1:0] quo_st   [0:STAGES];
   logic [NW-1:0]                   count_st [0:STAGES-1];
   flags_type                       flags_st [0:STAGES];
   status_type                      status;

   sbb_window #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_RADIUS (MAX_RADIUS),
      .SW         (SW),
      .NW         (NW)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .emit_valid (valid_st[0]),
      .emit_ready (ready_st[0]),
      .emit_sum   (rem_st[0]),
      .emit_count (count_st[0]),
      .emit_flags (flags_st[0]),
      .status     (status)
   );

   assign quo_st[0] = '0;

   // Restoring divider, most significant quotient bit first.
   for (genvar k = 0; k < STAGES; k++) begin : g_cell
      if (k < STAGES - 1) begin : g_mid
         sbb_div_cell #(
            .SW  (SW),
            .NW  (NW),
            .BIT (STAGES - 1 - k)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (valid_st[k]),
            .in_ready  (ready_st[k]),
            .in_rem    (rem_st[k]),
            .in_quo    (quo_st[k]),
            .in_count  (count_st[k]),
            .in_flags  (flags_st[k]),
            .out_valid (valid_st[k+1]),
            .out_ready (ready_st[k+1]),
            .out_rem   (rem_st[k+1]),
            .out_quo   (quo_st[k+1]),
            .out_count (count_st[k+1]),
            .out_flags (flags_st[k+1])
         );
      end else begin : g_last
         sbb_div_cell #(
            .SW  (SW),
            .NW  (NW),
            .BIT (STAGES - 1 - k)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (valid_st[k]),
            .in_ready  (ready_st[k]),
            .in_rem    (rem_st[k]),
            .in_quo    (quo_st[k]),
            .in_count  (count_st[k]),
            .in_flags  (flags_st[k]),
            .out_valid (valid_st[k+1]),
            .out_ready (ready_st[k+1]),
            .out_rem   (),
            .out_quo   (quo_st[k+1]),
            .out_count (),
            .out_flags (flags_st[k+1])
         );
      end
   end

   assign ready_st[STAGES] = rsp_tready;
   assign rsp_tvalid       = valid_st[STAGES];
   assign rsp_tdata        = quo_st[STAGES];
   assign rsp_tuser        = {flags_st[STAGES].frame_end, flags_st[STAGES].row_end};
   assign rsp_tlast        = flags_st[STAGES].run_last;

   // Entering the row-end flush always comes with a beat issued to the chain.
   a_flush_entry: assert property (@(posedge clock) disable iff (reset)
      $rose(status.flushing) |-> valid_st[0])
      else $error("flush entered without an issued beat");

   // A beat waiting at the head of the chain keeps its contents.
   a_issue_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_st[0] && !ready_st[0]) |=>
         (valid_st[0] && $stable(count_st[0]) && $stable(flags_st[0])))
      else $error("issued beat changed while stalled");

   // The window count that divides the sums is never zero.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_st[0] |-> (count_st[0] != '0))
      else $error("zero window count issued");

endmodule

// ===== tb/sliding_box_blur_row_test.sv =====
// Self-checking testbench for sliding_box_blur_row: random pixel rows under random
// back-pressure, checked beat by beat against a running-sum box blur predictor.
// Depends on sbb_pkg and the sliding_box_blur_row RTL only.
`timescale 1ns / 1ps

module sliding_box_blur_row_test;
   import sbb_pkg::*;

   localparam int IDLE_PERCENT = 38;
   localparam int STEADY_FROM  = 600;
   localparam int STEADY_TO    = 1100;
   localparam int DRAIN_PAD    = 64;
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 230;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_beat;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       row_end;
      logic       frame_end;
      logic       run_last;
   } blur_result;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [PIXEL_W-1:0]     req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [PIXEL_W-1:0]     rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   rsp_tlast;

   sliding_box_blur_row u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   pixel_beat  pixel_queue[$];
   blur_result blur_expected[$];
   int         error_count = 0;
   int         cycle_no = 0;
   int         stall_cycles = 0;
   bit         req_taken = 1'b0;

   // Shadow copy of the configuration and of the blur state.
   logic [9:0]  cfg_width;
   logic [9:0]  cfg_rows;
   logic [4:0]  cfg_radius;
   logic [23:0] pixel_store [64];
   logic [13:0] sum_red, sum_green, sum_blue;
   logic [8:0]  col_in;
   logic [9:0]  col_out;
   logic [8:0]  row_idx;

   function automatic bit idle_roll();
      if (cycle_no >= STEADY_FROM && cycle_no < STEADY_TO) return 1'b0;
      return $urandom_range(99) < IDLE_PERCENT;
   endfunction

   function automatic int eff_width();
      int w;
      w = cfg_width;
      if (w < 1) w = 1;
      if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
      return w;
   endfunction

   function automatic int eff_rows();
      int h;
      h = cfg_rows;
      if (h < 1) h = 1;
      if (h > DEF_MAX_HEIGHT) h = DEF_MAX_HEIGHT;
      return h;
   endfunction

   function automatic int eff_radius();
      int r;
      r = cfg_radius;
      if (r > DEF_MAX_RADIUS) r = DEF_MAX_RADIUS;
      return r;
   endfunction

   function automatic void restart_row();
      sum_red = '0;
      sum_green = '0;
      sum_blue = '0;
      col_in = '0;
      col_out = '0;
   endfunction

   // Takes one accepted pixel and queues every output column it completes.
   function automatic void blur_pixel(input pixel_beat px);
      int         w, h, r, c, x, lo, hi, count;
      bit         last_in;
      bit         have_pending;
      blur_result res, pending;
      logic [23:0] old;
      w = eff_width();
      h = eff_rows();
      r = eff_radius();
      c = int'(col_in);
      last_in = (c + 1 >= w);
      have_pending = 1'b0;
      pixel_store[c % 64] = {px.red, px.green, px.blue};
      sum_red += px.red;
      sum_green += px.green;
      sum_blue += px.blue;
      while (int'(col_out) < w && (last_in || int'(col_out) + r <= c)) begin
         x = int'(col_out);
         lo = (x > r) ? x - r : 0;
         hi = (x + r < w) ? x + r : w - 1;
         count = hi - lo + 1;
         res.red = 8'(int'(sum_red) / count);
         res.green = 8'(int'(sum_green) / count);
         res.blue = 8'(int'(sum_blue) / count);
         res.row_end = (x + 1 >= w);
         res.frame_end = res.row_end && (int'(row_idx) + 1 >= h);
         res.run_last = 1'b0;
         if (have_pending) blur_expected.push_back(pending);
         pending = res;
         have_pending = 1'b1;
         if (x >= r) begin
            old = pixel_store[(x - r) % 64];
            sum_red -= old[23:16];
            sum_green -= old[15:8];
            sum_blue -= old[7:0];
         end
         col_out = 10'(x + 1);
      end
      // The final window completed by this pixel closes the burst.
      if (have_pending) begin
         pending.run_last = 1'b1;
         blur_expected.push_back(pending);
      end
      if (last_in) begin
         restart_row();
         row_idx = (int'(row_idx) + 1 >= h) ? '0 : row_idx + 1'b1;
      end else begin
         col_in = 9'(c + 1);
      end
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   function automatic pixel_beat random_pixel();
      pixel_beat px;
      logic [7:0] chan [3];
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(7))
            0: chan[i] = 8'h00;
            1: chan[i] = 8'hff;
            default: chan[i] = 8'($urandom_range(255));
         endcase
      end
      px.red = chan[0];
      px.green = chan[1];
      px.blue = chan[2];
      return px;
   endfunction

   task automatic push_rgb(input logic [7:0] red, green, blue);
      pixel_beat px;
      px.red = red;
      px.green = green;
      px.blue = blue;
      pixel_queue.push_back(px);
   endtask

   // Waits until every pixel is taken and every result seen, then lets the
   // pipeline settle in case the last pixels completed no window.
   task automatic wait_idle();
      while (!(pixel_queue.size() == 0 && !req_tvalid && blur_expected.size() == 0))
         @(posedge clock);
      repeat (DRAIN_PAD) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_ROW_WIDTH:   cfg_width = val;
         CSR_ROW_COUNT:   cfg_rows = val;
         CSR_BLUR_RADIUS: cfg_radius = val[4:0];
         default: ;
      endcase
      restart_row();
      row_idx = '0;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic run_phase(input logic [9:0] w, h, input logic [4:0] r, input int n);
      wait_idle();
      write_csr(CSR_ROW_WIDTH, w);
      write_csr(CSR_ROW_COUNT, h);
      write_csr(CSR_BLUR_RADIUS, {5'd0, r});
      for (int k = 0; k < n; k++) pixel_queue.push_back(random_pixel());
   endtask

   // Driver: a new beat is presented only once the previous one was taken.
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         if (pixel_queue.size() != 0 && !idle_roll()) begin
            req_tdata <= pixel_queue.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= !idle_roll();
   end

   always @(posedge clock) begin : monitor
      blur_result want;
      cycle_no++;
      req_taken = !reset && req_tvalid && req_tready;
      if (reset || req_taken || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (blur_expected.size() == 0) begin
            $error("result beat with no pending expectation: data %h user %b last %b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            error_count++;
         end else begin
            want = blur_expected.pop_front();
            check_field("out_red", want.red, rsp_tdata[7:0]);
            check_field("out_green", want.green, rsp_tdata[15:8]);
            check_field("out_blue", want.blue, rsp_tdata[23:16]);
            check_field("row_end", want.row_end, rsp_tuser[0]);
            check_field("frame_end", want.frame_end, rsp_tuser[1]);
            check_field("run_last", want.run_last, rsp_tlast);
         end
      end
      if (req_taken) blur_pixel(pixel_beat'(req_tdata));
   end

   initial begin : watchdog
      wait (stall_cycles >= STALL_LIMIT);
      $display("** sliding_box_blur_row: FAILED **");
      $finish;
   end

   initial begin : main
      logic [9:0] w, h;
      logic [4:0] r;
      int         ew, n, random_items;
      cfg_width = RESET_ROW_WIDTH;
      cfg_rows = RESET_ROW_COUNT;
      cfg_radius = RESET_BLUR_RADIUS;
      for (int i = 0; i < 64; i++) pixel_store[i] = '0;
      restart_row();
      row_idx = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings; the row is left unfinished so the next write restarts it.
      push_rgb(8'h00, 8'h00, 8'h00);
      push_rgb(8'hff, 8'hff, 8'hff);
      push_rgb(8'hff, 8'h00, 8'h00);
      push_rgb(8'h00, 8'hff, 8'h00);
      push_rgb(8'h00, 8'h00, 8'hff);
      push_rgb(8'haa, 8'h55, 8'haa);
      push_rgb(8'h55, 8'haa, 8'h55);
      push_rgb(8'hff, 8'hff, 8'hff);
      push_rgb(8'h01, 8'h02, 8'h03);
      push_rgb(8'hfe, 8'hfd, 8'hfc);
      push_rgb(8'h80, 8'h7f, 8'h01);
      push_rgb(8'hff, 8'hff, 8'hff);
      // Zero width and zero row count behave as one.
      run_phase(10'd0, 10'd0, 5'd0, 3);
      // Radius beyond the maximum on a one-pixel row.
      run_phase(10'd1, 10'd1, 5'd31, 3);
      // Radius wider than the row: the early pixels complete no window.
      run_phase(10'd3, 10'd2, 5'd31, 6);

      // Over-wide row with the largest radius; the pixel store wraps within the row.
      run_phase(10'd1023, 10'd1, 5'd28, 80);
      // Over-tall frame at width one, every pixel a row of its own.
      run_phase(10'd1, 10'd1023, 5'd0, 24);

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4: w = 10'($urandom_range(1, 12));
            5, 6:          w = 10'($urandom_range(13, 40));
            7:             w = 10'($urandom_range(60, 100));
            8:             w = 10'd0;
            default:       w = 10'($urandom_range(1, 2));
         endcase
         r = ($urandom_range(3) == 0) ? 5'($urandom_range(9, 31)) : 5'($urandom_range(0, 8));
         case ($urandom_range(7))
            0:       h = 10'd0;
            1:       h = 10'($urandom_range(512, 1023));
            default: h = 10'($urandom_range(1, 4));
         endcase
         ew = (w == 0) ? 1 : int'(w);
         n = $urandom_range(1, 3) * ew;
         if ($urandom_range(3) == 0 && ew > 1) n += $urandom_range(1, ew - 1);
         if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;
         run_phase(w, h, r, n);
         random_items += n;
      end

      wait_idle();
      if (error_count == 0) begin
         $display("** sliding_box_blur_row: PASSED **");
      end else begin
         $display("** sliding_box_blur_row: FAILED **");
      end
      $finish;
   end

endmodule
